// ----- rtl/rabin_encrypt_decrypt_defines.svh -----
// ---------------------------------------------------------------------------
// Rabin block assertion macros
// Shared assertion helpers for the Rabin encrypt/decrypt RTL.
// ---------------------------------------------------------------------------
`ifndef RABIN_ENCRYPT_DECRYPT_DEFINES_SVH
`define RABIN_ENCRYPT_DECRYPT_DEFINES_SVH

// check an implication on every clock edge outside reset
`define RED_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rabin check failed");

// check an implication in the next cycle
`define RED_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rabin check failed");

`endif

// ----- rtl/rabin_pkg.sv -----
// ---------------------------------------------------------------------------
// Rabin package
// Widths and opcodes shared by the Rabin encrypt/decrypt modules.
// ---------------------------------------------------------------------------
`default_nettype none
package rabin_pkg;
   localparam int PRIME_BITS_DEF = 16;
   localparam int KEY_W          = 16;
   localparam int VAL_W          = 32;
   localparam logic [15:0] P_RESET = 16'd7;
   localparam logic [15:0] Q_RESET = 16'd11;
   localparam logic        REG_P   = 1'b0;
   localparam logic        REG_Q   = 1'b1;
   localparam logic        OP_ENC  = 1'b0;
   localparam logic        OP_DEC  = 1'b1;
   // modular unit operations
   localparam logic [1:0]  MU_MUL  = 2'd0;
   localparam logic [1:0]  MU_RED  = 2'd1;
   typedef struct packed {
      logic [1:0] op;
      logic       start;
   } mu_cmd_type;
endpackage
`default_nettype wire

// ----- rtl/rabin_modmul.sv -----
// ---------------------------------------------------------------------------
// Rabin bit-serial modular multiplier
// Interleaved shift-add: one multiplier bit per cycle, result a*b mod m.
// Reduce mode: a*1 mod m for a 32-bit a.
// ---------------------------------------------------------------------------
`default_nettype none
module rabin_modmul import rabin_pkg::*; (
   input  wire              clock,
   input  wire              reset,
   input  wire mu_cmd_type  cmd,
   input  wire [VAL_W-1:0]  a,
   input  wire [VAL_W-1:0]  b,
   input  wire [VAL_W-1:0]  m,
   output logic [VAL_W-1:0] res,
   output logic             done
);
   // red: r = 2r + bit(a) mod m ; mul: r = 2r + (bit(b)? a : 0) mod m, a < m
   logic [VAL_W-1:0] acc_ff, acc_in, sh_ff, sh_in, a_ff, a_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in, mul_ff, mul_in;
   logic [VAL_W+1:0] t1, t2;

   always_comb begin
      acc_in = acc_ff; sh_in = sh_ff; a_in = a_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0; mul_in = mul_ff;
      t1 = {2'b0, acc_ff} << 1;
      if (t1 >= {2'b0, m}) t1 = t1 - {2'b0, m};
      if (mul_ff) t2 = t1 + (sh_ff[VAL_W-1] ? {2'b0, a_ff} : '0);
      else        t2 = t1 + {{(VAL_W+1){1'b0}}, sh_ff[VAL_W-1]};
      if (t2 >= {2'b0, m}) t2 = t2 - {2'b0, m};
      if (cmd.start) begin
         acc_in = '0; busy_in = 1'b1; cnt_in = 6'(VAL_W);
         mul_in = (cmd.op == MU_MUL);
         sh_in  = (cmd.op == MU_MUL) ? b : a;
         a_in   = a;
      end else if (busy_ff) begin
         acc_in = t2[VAL_W-1:0];
         sh_in  = sh_ff << 1;
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in; sh_ff <= sh_in; a_ff <= a_in; cnt_ff <= cnt_in;
      mul_ff <= mul_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign res  = acc_ff;
   assign done = done_ff;
endmodule
`default_nettype wire

// ----- rtl/rabin_encrypt_decrypt.sv -----
// On a bad key the response carries key_error with all-zero data and no computation.
// Throughput: one transaction at a time; the next is taken once the result is taken.
// The bit-serial modular multiplier performs the reductions, the encrypt squaring, both
// exponentiations and the CRT products; each Euclid step runs a bit-serial divider
// between its S_EU and S_EUW states.
// Reset (synchronous, active high): keys return to p = 7, q = 11, control to idle.
// ---------------------------------------------------------------------------
// Rabin encrypt/decrypt top level
// Sequencer around a shared bit-serial modular multiplier.
// ---------------------------------------------------------------------------
`default_nettype none
module rabin_encrypt_decrypt import rabin_pkg::*; #(
   parameter int PRIME_BITS = PRIME_BITS_DEF
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire          csr_index,
   input  wire  [15:0]  csr_data,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [31:0]  req_tdata,   // value_in
   input  wire          req_tuser,   // req_type
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [159:0] rsp_tdata,   // cipher_out, cand_one, cand_two, cand_three, cand_four
   output logic         rsp_tuser    // key_error
);
`include "rabin_encrypt_decrypt_defines.svh"
   localparam logic [4:0] S_IDLE = 5'd0, S_RED = 5'd1, S_ENCW = 5'd2, S_PX = 5'd3,
      S_PW = 5'd4, S_QX = 5'd5, S_QW = 5'd6, S_EU = 5'd7, S_EUW = 5'd8, S_EUF = 5'd9,
      S_C1 = 5'd10, S_C1W = 5'd11, S_C2 = 5'd12, S_C2W = 5'd13, S_SUM = 5'd14,
      S_OUT = 5'd15, S_PSQ = 5'd16, S_PSQW = 5'd17, S_DIV = 5'd18, S_RRED = 5'd19,
      S_RREDW = 5'd20;

   logic [15:0] p_ff, q_ff;
   logic [15:0] pk, qk;
   logic [4:0]  st_ff, st_in;
   logic        op_ff;
   logic [31:0] v_ff, n_ff, m_ff, b_ff, e_ff, r_ff;
   logic [31:0] rp_ff, rq_ff, ia_ff, ib_ff, ta1_ff, ta2_ff, tb1_ff, tb2_ff;
   logic [1:0]  ph_ff;          // phase: which root / which inverse / which product
   logic [4:0]  bit_ff;         // exponent bit position
   // Euclid state
   logic [16:0] r0_ff, r1_ff, qt_ff, rem_ff;
   logic signed [18:0] t0_ff, t1_ff;
   logic [4:0]  dc_ff;
   logic [159:0] out_ff;
   logic         kerr_ff, vld_ff;
   mu_cmd_type   cmd;
   logic [31:0]  ma, mb, mres;
   logic         mdone;
   logic         key_bad;

   assign pk = (PRIME_BITS < 16) ? (p_ff & 16'((32'd1 << PRIME_BITS) - 1)) : p_ff;
   assign qk = (PRIME_BITS < 16) ? (q_ff & 16'((32'd1 << PRIME_BITS) - 1)) : q_ff;
   assign key_bad = (pk == qk) || (pk[1:0] != 2'b11) || (qk[1:0] != 2'b11);

   rabin_modmul u_mm (.clock(clock), .reset(reset), .cmd(cmd), .a(ma), .b(mb),
                      .m(m_ff), .res(mres), .done(mdone));

   assign csr_ready  = 1'b1;
   assign req_tready = (st_ff == S_IDLE) && !vld_ff;
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tuser  = kerr_ff;

   logic [32:0] sum;
   logic [17:0] dtrial;
   always_comb begin
      sum = {1'b0, (ph_ff[1] ? ta2_ff : ta1_ff)} + {1'b0, (ph_ff[0] ? tb2_ff : tb1_ff)};
      if (sum >= {1'b0, n_ff}) sum = sum - {1'b0, n_ff};
      dtrial = {rem_ff, qt_ff[16]} - {1'b0, r1_ff};
   end

   always_comb begin
      cmd = '0; ma = r_ff; mb = b_ff; st_in = st_ff;
      unique case (st_ff)
         S_RED:  begin cmd.start = 1'b1; cmd.op = MU_RED; ma = v_ff; st_in = S_ENCW; end
         S_PX:   begin cmd.start = 1'b1; cmd.op = MU_MUL; ma = v_ff; mb = v_ff; st_in = S_PW; end
         S_PSQ:  begin cmd.start = 1'b1; cmd.op = MU_MUL; ma = r_ff; mb = b_ff; st_in = S_PSQW; end
         S_RRED: begin cmd.start = 1'b1; cmd.op = MU_RED; ma = v_ff; st_in = S_RREDW; end
         S_C1:   begin
            cmd.start = 1'b1; cmd.op = MU_MUL;
            ma = ph_ff[1] ? {16'd0, pk} : {16'd0, qk};
            mb = ph_ff[0] ? (ph_ff[1] ? (rq_ff == 0 ? 32'd0 : {16'd0, qk} - rq_ff)
                                      : (rp_ff == 0 ? 32'd0 : {16'd0, pk} - rp_ff))
                          : (ph_ff[1] ? rq_ff : rp_ff);
            st_in = S_C1W;
         end
         S_C2:   begin
            cmd.start = 1'b1; cmd.op = MU_MUL; ma = r_ff;
            mb = ph_ff[1] ? ib_ff : ia_ff; st_in = S_C2W;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff <= P_RESET; q_ff <= Q_RESET; st_ff <= S_IDLE; vld_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_P) p_ff <= csr_data; else q_ff <= csr_data;
         end
         if (vld_ff && rsp_tready) vld_ff <= 1'b0;
         unique case (st_ff)
            S_IDLE: if (req_tvalid && req_tready) begin
               v_ff <= req_tdata; op_ff <= req_tuser;
               n_ff <= 32'(pk) * 32'(qk); m_ff <= 32'(pk) * 32'(qk);
               if (key_bad) begin
                  out_ff <= '0; kerr_ff <= 1'b1; vld_ff <= 1'b1;
               end else st_ff <= S_RED;
            end
            S_RED, S_PX, S_PSQ, S_RRED, S_C1, S_C2: st_ff <= st_in;
            S_ENCW: if (mdone) begin
               v_ff <= mres;
               if (op_ff == OP_ENC) begin
                  m_ff <= n_ff; st_ff <= S_PX;
               end else begin
                  ph_ff <= 2'd0; st_ff <= S_RRED; m_ff <= {16'd0, pk};
               end
            end
            S_PW: if (mdone) begin
               out_ff <= {128'd0, mres}; kerr_ff <= 1'b0; vld_ff <= 1'b1; st_ff <= S_IDLE;
            end
            S_RREDW: if (mdone) begin
               // base = c mod prime; exponent (prime+1)/4
               b_ff <= mres; r_ff <= 32'd1;
               e_ff <= ph_ff[0] ? 32'(({16'd0, qk} + 32'd1) >> 2)
                                : 32'(({16'd0, pk} + 32'd1) >> 2);
               bit_ff <= 5'd16; st_ff <= S_QX;
            end
            S_QX: begin
               // left-to-right: square, then multiply when bit set
               if (bit_ff == 5'd0) begin
                  if (ph_ff[0]) begin
                     rq_ff <= r_ff; ph_ff <= 2'd0;
                     r0_ff <= {1'b0, pk}; r1_ff <= {1'b0, qk};
                     t0_ff <= '0; t1_ff <= 19'sd1; st_ff <= S_EU;
                  end else begin
                     rp_ff <= r_ff; ph_ff <= 2'd1; m_ff <= {16'd0, qk}; st_ff <= S_RRED;
                  end
               end else begin
                  st_ff <= S_PSQ;
                  ta1_ff <= b_ff; // save base
                  b_ff <= r_ff;   // square r
               end
            end
            S_PSQW: if (mdone) begin
               if (ph_ff[1]) begin
                  r_ff <= mres; b_ff <= ta1_ff; ph_ff[1] <= 1'b0;
                  bit_ff <= bit_ff - 5'd1; st_ff <= S_QX;
               end else if (e_ff[bit_ff-5'd1]) begin
                  r_ff <= mres; b_ff <= ta1_ff; ph_ff[1] <= 1'b1; st_ff <= S_PSQ;
               end else begin
                  r_ff <= mres; b_ff <= ta1_ff; bit_ff <= bit_ff - 5'd1; st_ff <= S_QX;
               end
            end
            S_EU: begin
               if (r1_ff == 0) st_ff <= S_EUF;
               else begin
                  qt_ff <= r0_ff; rem_ff <= '0; dc_ff <= 5'd17; st_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (!dtrial[17]) rem_ff <= dtrial[16:0];
               else rem_ff <= {rem_ff[15:0], qt_ff[16]};
               qt_ff <= {qt_ff[15:0], !dtrial[17]};
               dc_ff <= dc_ff - 5'd1;
               if (dc_ff == 5'd1) st_ff <= S_EUW;
            end
            S_EUW: begin
               r0_ff <= r1_ff; r1_ff <= rem_ff;
               t0_ff <= t1_ff;
               t1_ff <= 19'(t0_ff - $signed({2'b0, qt_ff}) * t1_ff);
               st_ff <= S_EU;
            end
            S_EUF: begin
               if (!ph_ff[0]) begin
                  ia_ff <= 32'(t0_ff < 0 ? t0_ff + $signed({3'b0, pk}) : t0_ff);
                  ph_ff <= 2'd1; r0_ff <= {1'b0, qk}; r1_ff <= {1'b0, pk};
                  t0_ff <= '0; t1_ff <= 19'sd1; st_ff <= S_EU;
               end else begin
                  ib_ff <= 32'(t0_ff < 0 ? t0_ff + $signed({3'b0, qk}) : t0_ff);
                  ph_ff <= 2'd0; m_ff <= n_ff; st_ff <= S_C1;
               end
            end
            S_C1W: if (mdone) begin r_ff <= mres; st_ff <= S_C2; end
            S_C2W: if (mdone) begin
               unique case (ph_ff)
                  2'd0: ta1_ff <= mres;
                  2'd1: ta2_ff <= mres;
                  2'd2: tb1_ff <= mres;
                  default: tb2_ff <= mres;
               endcase
               ph_ff <= ph_ff + 2'd1;
               st_ff <= (ph_ff == 2'd3) ? S_SUM : S_C1;
            end
            S_SUM: begin
               ph_ff <= ph_ff + 2'd1;
               out_ff <= {sum[31:0], out_ff[159:64], 32'd0};
               if (ph_ff == 2'd3) begin
                  kerr_ff <= 1'b0; vld_ff <= 1'b1; st_ff <= S_IDLE;
               end
            end
            default: ;
         endcase
      end
   end

   `RED_ASSERT_IMP(a_busy_nrdy, st_ff != S_IDLE, !req_tready)
   `RED_ASSERT_NXT(a_kerr_zero, rsp_tvalid && rsp_tuser, rsp_tdata == '0)
   `RED_ASSERT_IMP(a_vld_idle, rsp_tvalid, st_ff == S_IDLE)
endmodule
`default_nettype wire
